// ----- rtl/vsrr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the voxel span rasterizer.
// Used by the front decoder, the command queue, the back stage and the top level.
package vsrr_pkg;

    // Widths fixed by the item and register fields.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 24;
    localparam int unsigned STEP_W = 16;
    localparam int unsigned PIX_W  = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_STEP_X = 2'd0;
    localparam logic [IDX_W-1:0] CFG_STEP_Y = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DEPTH  = 2'd2;

    // Result kinds.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_COL_END = 1'b1;

    // Commands that the front hands to the back.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_SKIP  = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] arg;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } t_cmd;

endpackage

// ----- rtl/vsrr_front.sv -----
`timescale 1ns / 1ps
// Front decoder: walks the span bytes through the block phases, keeps the run and
// depth counters and turns each byte into at most one command. Uses vsrr_pkg.
module vsrr_front
    import vsrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_queue_full,
    input  logic [BYTE_W-1:0] i_span_byte,
    input  logic              i_column_begin,
    input  logic [POS_W-1:0]  i_start_x,
    input  logic [POS_W-1:0]  i_start_y,
    input  logic [BYTE_W-1:0] i_depth_size,
    output logic              o_push,
    output t_cmd              o_cmd
);

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_RUN        = 6'b000010,
        PH_PAD_COLOUR = 6'b000100,
        PH_COLOUR     = 6'b001000,
        PH_PAD_SKIP   = 6'b010000,
        PH_SKIP       = 6'b100000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_run_left, n_run_left;
    logic [BYTE_W-1:0] r_depth_left, n_depth_left;

    logic              w_accept;
    logic [BYTE_W-1:0] w_run_dec;
    logic [BYTE_W-1:0] w_depth_skip;

    assign w_accept     = i_in_valid && !i_queue_full;
    assign w_run_dec    = r_run_left - 1'b1;
    assign w_depth_skip = r_depth_left - i_span_byte;

    // Phase step for one accepted request and the command it produces.
    always_comb begin
        n_phase      = r_phase;
        n_run_left   = r_run_left;
        n_depth_left = r_depth_left;
        o_push       = 1'b0;
        o_cmd.op     = OP_PIXEL;
        o_cmd.arg    = i_span_byte;
        o_cmd.pos_x  = i_start_x;
        o_cmd.pos_y  = i_start_y;
        if (w_accept) begin
            if (i_column_begin) begin
                n_depth_left = i_depth_size;
                o_push       = 1'b1;
                if (i_depth_size == '0) begin
                    // An empty column finishes at once.
                    n_run_left = '0;
                    n_phase    = PH_IDLE;
                    o_cmd.op   = OP_END;
                end else begin
                    n_run_left = i_span_byte;
                    n_phase    = (i_span_byte != '0) ? PH_PAD_COLOUR : PH_PAD_SKIP;
                    o_cmd.op   = OP_LOAD;
                end
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_RUN: begin
                        n_run_left = i_span_byte;
                        n_phase    = (i_span_byte != '0) ? PH_PAD_COLOUR : PH_PAD_SKIP;
                    end
                    PH_PAD_COLOUR: begin
                        n_phase = PH_COLOUR;
                    end
                    PH_COLOUR: begin
                        o_push       = 1'b1;
                        o_cmd.op     = OP_PIXEL;
                        n_depth_left = r_depth_left - 1'b1;
                        n_run_left   = w_run_dec;
                        n_phase      = (w_run_dec != '0) ? PH_PAD_COLOUR : PH_PAD_SKIP;
                    end
                    PH_PAD_SKIP: begin
                        n_phase = PH_SKIP;
                    end
                    PH_SKIP: begin
                        o_push       = 1'b1;
                        n_depth_left = w_depth_skip;
                        if (w_depth_skip == '0) begin
                            o_cmd.op = OP_END;
                            n_phase  = PH_IDLE;
                        end else begin
                            o_cmd.op = OP_SKIP;
                            n_phase  = PH_RUN;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Phase and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_run_left   <= '0;
            r_depth_left <= '0;
        end else begin
            r_phase      <= n_phase;
            r_run_left   <= n_run_left;
            r_depth_left <= n_depth_left;
        end
    end

endmodule

// ----- rtl/vsrr_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front decoder and the back stage.
// Holds t_cmd entries from vsrr_pkg; DEPTH must be at least two.
module vsrr_queue
    import vsrr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/vsrr_back.sv -----
`timescale 1ns / 1ps
// Back stage: carries out queued commands on the 16.8 position accumulators and
// drives the result register. Uses vsrr_pkg.
module vsrr_back
    import vsrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    input  logic [STEP_W-1:0] i_step_x,
    input  logic [STEP_W-1:0] i_step_y,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_result_kind,
    output logic [PIX_W-1:0]  o_pixel_x,
    output logic [PIX_W-1:0]  o_pixel_y,
    output logic [BYTE_W-1:0] o_pixel_colour
);

    // Only the upper 16 bits of the 24-bit accumulators reach the outputs.
    logic [POS_W-1:0]  r_acc_x, n_acc_x;
    logic [POS_W-1:0]  r_acc_y, n_acc_y;
    logic              r_out_valid;
    logic              r_kind;
    logic [PIX_W-1:0]  r_pix_x;
    logic [PIX_W-1:0]  r_pix_y;
    logic [BYTE_W-1:0] r_colour;

    logic                     w_out_free;
    logic                     w_emits;
    logic [BYTE_W-1:0]        w_factor;
    logic signed [POS_W:0]    w_prod_x;
    logic signed [POS_W:0]    w_prod_y;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emits    = (i_cmd.op == OP_PIXEL) || (i_cmd.op == OP_END);
    assign o_pop      = i_cmd_valid && (w_out_free || !w_emits);

    // A pixel steps once along Z, a skip steps by its count.
    assign w_factor = (i_cmd.op == OP_PIXEL) ? BYTE_W'(1) : i_cmd.arg;
    assign w_prod_x = $signed(i_step_x) * $signed({1'b0, w_factor});
    assign w_prod_y = $signed(i_step_y) * $signed({1'b0, w_factor});

    always_comb begin
        n_acc_x = r_acc_x;
        n_acc_y = r_acc_y;
        if (o_pop) begin
            case (i_cmd.op)
                OP_LOAD: begin
                    n_acc_x = i_cmd.pos_x;
                    n_acc_y = i_cmd.pos_y;
                end
                OP_PIXEL, OP_SKIP: begin
                    n_acc_x = r_acc_x + w_prod_x[POS_W-1:0];
                    n_acc_y = r_acc_y + w_prod_y[POS_W-1:0];
                end
                default: begin
                    n_acc_x = r_acc_x;
                    n_acc_y = r_acc_y;
                end
            endcase
        end
    end

    // Accumulators and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_x <= n_acc_x;
            r_acc_y <= n_acc_y;
            if (o_pop && w_emits) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; a column end carries zero fields.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emits) begin
            if (i_cmd.op == OP_PIXEL) begin
                r_kind   <= KIND_PIXEL;
                r_pix_x  <= r_acc_x[POS_W-1:POS_W-PIX_W];
                r_pix_y  <= r_acc_y[POS_W-1:POS_W-PIX_W];
                r_colour <= i_cmd.arg;
            end else begin
                r_kind   <= KIND_COL_END;
                r_pix_x  <= '0;
                r_pix_y  <= '0;
                r_colour <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_pixel_x      = r_pix_x;
    assign o_pixel_y      = r_pix_y;
    assign o_pixel_colour = r_colour;

endmodule

// ----- rtl/voxel_span_rle_rasterizer.sv -----
`timescale 1ns / 1ps
// Voxel column span decoder. Span bytes enter one per cycle while o_in_stall is low,
// backward from the column terminator; each byte that gives a pixel or a column end
// is pushed as a command into the queue and loads the result register when the back
// stage pops it while the output is free. The front decoder keeps the block phase and
// depth counter, a QUEUE_DEPTH-entry command queue decouples it from the back stage,
// whose two 16x8 multiply-adds, one per axis, step the 16.8 accumulators. Sustained
// rate is one byte per cycle while the output is not stalled; input stall rises only
// when the queue is full. Depends on vsrr_pkg, vsrr_front, vsrr_queue and vsrr_back.
module voxel_span_rle_rasterizer
    import vsrr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_span_byte,
    input  logic              i_column_begin,
    input  logic [POS_W-1:0]  i_start_x,
    input  logic [POS_W-1:0]  i_start_y,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_result_kind,
    output logic [PIX_W-1:0]  o_pixel_x,
    output logic [PIX_W-1:0]  o_pixel_y,
    output logic [BYTE_W-1:0] o_pixel_colour
);

    logic [STEP_W-1:0] r_step_x;
    logic [STEP_W-1:0] r_step_y;
    logic [BYTE_W-1:0] r_depth_size;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_depth_size <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP_X: r_step_x     <= i_cfg_data;
                CFG_STEP_Y: r_step_y     <= i_cfg_data;
                CFG_DEPTH:  r_depth_size <= i_cfg_data[BYTE_W-1:0];
                default: begin
                    r_step_x <= r_step_x;
                end
            endcase
        end
    end

    assign o_in_stall = w_full;

    // Front decoder.
    vsrr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_queue_full   (w_full),
        .i_span_byte    (i_span_byte),
        .i_column_begin (i_column_begin),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_depth_size   (r_depth_size),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    // Command queue.
    vsrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // Back stage with the result register.
    vsrr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .i_step_x       (r_step_x),
        .i_step_y       (r_step_y),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour)
    );

endmodule
